// ----- sv/dwo_pkg.sv -----
`default_nettype none
package dwo_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W = 6;
  localparam int CW = 34;

  localparam int DIV_W = 74;
  localparam int DCNT_W = $clog2(DIV_W + 1);
  localparam int ACC_W = 104;

  localparam logic [63:0] YAW_K = (64'h28BE60DB9391 << 16) / 64'd1000;
  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(32'h26DD3B6A);
  localparam logic [63:0] POS_RCP = ((64'd1 << 58) + 64'd999) / 64'd1000;

  typedef enum logic [2:0] {
    REG_INV_L = 3'd0,
    REG_INV_R = 3'd1,
    REG_MPT   = 3'd2,
    REG_ITW   = 3'd3,
    REG_NOM   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SH_0  = 2'd0,
    SH_32 = 2'd1,
    SH_64 = 2'd2
  } mac_sh_t;

  typedef struct packed {
    logic    en;
    logic    clr;
    mac_sh_t sh;
  } mac_ctl_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      5'd31: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/dwo_mac.sv -----
`default_nettype none
module dwo_mac (
  input  logic                      clk,
  input  dwo_pkg::mac_ctl_t         ctl,
  input  logic [31:0]               a,
  input  logic [31:0]               b,
  output logic [dwo_pkg::ACC_W-1:0] acc
);
  import dwo_pkg::*;

  logic [63:0]      prod;
  logic [ACC_W-1:0] addend;
  logic [ACC_W-1:0] base;

  assign prod = a * b;

  always_comb begin
    unique case (ctl.sh)
      SH_0:    addend = ACC_W'(prod);
      SH_32:   addend = ACC_W'(prod) << 32;
      SH_64:   addend = ACC_W'(prod) << 64;
      default: addend = '0;
    endcase
    base = ctl.clr ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc <= base + addend;
    end
  end

endmodule
`default_nettype wire

// ----- sv/dwo_div.sv -----
`default_nettype none
module dwo_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [dwo_pkg::DIV_W-1:0] dividend,
  input  logic [15:0]               divisor,
  output logic                      busy,
  output logic [dwo_pkg::DIV_W-1:0] quotient
);
  import dwo_pkg::*;

  logic [DCNT_W-1:0] cnt;
  logic [15:0]       rem;
  logic [16:0]       shifted;
  logic [16:0]       trial;

  assign shifted = {rem, quotient[DIV_W-1]};
  assign trial   = shifted - {1'b0, divisor};
  assign busy    = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DCNT_W'(DIV_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      quotient <= {quotient[DIV_W-2:0], ~trial[16]};
      rem      <= trial[16] ? shifted[15:0] : trial[15:0];
    end
  end

endmodule
`default_nettype wire

// ----- sv/dwo_cordic.sv -----
`default_nettype none
module dwo_cordic (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [31:0]                   angle,
  output logic                          busy,
  output logic signed [dwo_pkg::CW-1:0] cos_out,
  output logic signed [dwo_pkg::CW-1:0] sin_out
);
  import dwo_pkg::*;

  logic [STEP_W-1:0]   step;
  logic [31:0]         ang_q;
  logic                flip;
  logic                flip_r;
  logic [31:0]         ang_f;
  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] z;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] at;

  assign ang_q = angle + 32'h4000_0000;
  assign flip  = ang_q[31];
  assign ang_f = angle ^ {flip, 31'b0};
  assign busy  = (step != STEP_W'(CORDIC_STEPS));
  assign dx    = x >>> step[4:0];
  assign dy    = y >>> step[4:0];
  assign at    = $signed({{(CW-32){1'b0}}, atan_lut(step[4:0])});

  assign cos_out = flip_r ? -x : x;
  assign sin_out = flip_r ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_W'(CORDIC_STEPS);
    end else if (start) begin
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      flip_r <= flip;
      x      <= CORDIC_GAIN;
      y      <= '0;
      z      <= $signed({{(CW-32){ang_f[31]}}, ang_f});
    end else if (busy) begin
      if (!z[CW-1]) begin
        x <= x - dy;
        y <= y + dx;
        z <= z - at;
      end else begin
        x <= x + dy;
        y <= y - dx;
        z <= z + at;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/diff_drive_wheel_odometry.sv -----
// Differential-drive wheel odometry, one pose update per control tick.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready is always
// high; write only while no tick is in flight. Indexes past the last register
// are ignored.
// Input channel (in_valid/in_ready): one tick carries both encoder counts, the
// period and the gyro rate. in_ready is high only while the sequencer is idle.
// Each tick runs on one shared 32x32 multiply-accumulate unit, one radix-2
// restoring divider (two divisions per tick) and a CORDIC rotator (24 steps).
// A new tick is taken only after the previous tick's result has been written
// to the output register.
// Output channel (out_valid/out_ready): the result sits in an output register.
// When the receiver stalls, the finished result waits there and the next tick
// is still taken; its own result is held back until the register frees, and
// the stored pose advances only when that result is written.
// Reset clears pose, heading, stored counts and registers (nominal period 10 ms).
`default_nettype none
module diff_drive_wheel_odometry (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] left_count,
  input  logic signed [31:0] right_count,
  input  logic [15:0]        period_ms,
  input  logic               imu_valid,
  input  logic signed [23:0] imu_yaw_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] left_speed,
  output logic signed [31:0] right_speed,
  output logic signed [31:0] linear_speed,
  output logic signed [31:0] wheel_turn_rate,
  output logic signed [31:0] pose_x,
  output logic signed [31:0] pose_y,
  output logic [31:0]        heading
);
  import dwo_pkg::*;

  typedef enum logic [21:0] {
    S_IDLE = 22'h000001,
    S_WM   = 22'h000002,
    S_WD   = 22'h000004,
    S_WW   = 22'h000008,
    S_TM   = 22'h000010,
    S_TN   = 22'h000020,
    S_AM   = 22'h000040,
    S_K0   = 22'h000080,
    S_K1   = 22'h000100,
    S_K2   = 22'h000200,
    S_K3   = 22'h000400,
    S_YW   = 22'h000800,
    S_CW   = 22'h001000,
    S_PM0  = 22'h002000,
    S_PM1  = 22'h004000,
    S_PM2  = 22'h008000,
    S_PD   = 22'h010000,
    S_R1   = 22'h020000,
    S_R2   = 22'h040000,
    S_R3   = 22'h080000,
    S_PW   = 22'h100000,
    S_OUT  = 22'h200000
  } state_t;

  state_t state;

  logic        inv_l;
  logic        inv_r;
  logic [31:0] mpt;
  logic [23:0] itw;
  logic [15:0] nom_p;

  logic [31:0]        prev_l;
  logic [31:0]        prev_r;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic [31:0]        yaw;

  logic [31:0]          cur_l;
  logic [31:0]          cur_r;
  logic [15:0]          per;
  logic                 imu_ok;
  logic signed [23:0]   gyro;
  logic                 side;
  logic signed [31:0]   ls;
  logic signed [31:0]   rs;
  logic signed [31:0]   lin;
  logic signed [31:0]   turn;
  logic signed [31:0]   omega;
  logic [31:0]          dmag;
  logic signed [CW-1:0] cs;
  logic signed [CW-1:0] sn;
  logic [61:0]          tmp;
  logic signed [31:0]   new_x;
  logic signed [31:0]   new_y;

  mac_ctl_t         mac_ctl;
  logic [31:0]      mac_a;
  logic [31:0]      mac_b;
  logic [ACC_W-1:0] acc;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [15:0]      div_divisor;
  logic             div_busy;
  logic [DIV_W-1:0] div_q;

  logic                 cor_busy;
  logic signed [CW-1:0] cor_cos;
  logic signed [CW-1:0] cor_sin;
  logic [31:0]          mid;

  logic [15:0]        per_in;
  logic [31:0]        delta;
  logic               dneg;
  logic [31:0]        dabs;
  logic [DIV_W-1:0]   m_ext;
  logic [57:0]        spd;
  logic [31:0]        wsp;
  logic [32:0]        diff;
  logic [32:0]        diff_abs;
  logic [39:0]        tq;
  logic [31:0]        turn_c;
  logic [32:0]        sum;
  logic [32:0]        sum_adj;
  logic [31:0]        omega_c;
  logic               oneg;
  logic [31:0]        oabs;
  logic [31:0]        dm;
  logic [31:0]        hm;
  logic signed [CW-1:0] trig;
  logic [CW-1:0]      trig_abs;
  logic [31:0]        labs;
  logic               pneg;
  logic [40:0]        qq;
  logic signed [40:0] psum;
  logic signed [31:0] pbase;
  logic signed [31:0] psat;
  logic               out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  assign per_in = (period_ms != '0) ? period_ms : ((nom_p != '0) ? nom_p : 16'd1);

  assign delta = side ? (cur_r - prev_r) : (cur_l - prev_l);
  assign dneg  = delta[31];
  assign dabs  = dneg ? (32'd0 - delta) : delta;
  assign m_ext = DIV_W'(acc[63:0]);
  assign spd   = div_q[DIV_W-1:16];

  always_comb begin
    if (dneg) begin
      wsp = (spd > 58'h8000_0000) ? 32'h8000_0000 : (32'd0 - spd[31:0]);
    end else begin
      wsp = (spd > 58'h7FFF_FFFF) ? 32'h7FFF_FFFF : spd[31:0];
    end
  end

  assign diff     = {rs[31], rs} - {ls[31], ls};
  assign diff_abs = diff[32] ? (33'd0 - diff) : diff;
  assign tq       = acc[55:16];

  always_comb begin
    if (diff[32]) begin
      turn_c = (tq > 40'h8000_0000) ? 32'h8000_0000 : (32'd0 - tq[31:0]);
    end else begin
      turn_c = (tq > 40'h7FFF_FFFF) ? 32'h7FFF_FFFF : tq[31:0];
    end
  end

  assign sum     = {ls[31], ls} + {rs[31], rs};
  assign sum_adj = sum + {32'd0, sum[32]};
  assign omega_c = imu_ok ? {{8{gyro[23]}}, gyro} : turn_c;

  assign oneg = omega[31];
  assign oabs = oneg ? (32'd0 - omega) : omega;
  assign dm   = oneg ? (32'd0 - acc[79:48]) : acc[79:48];
  assign hm   = oneg ? (32'd0 - acc[80:49]) : acc[80:49];
  assign mid  = yaw + hm;

  assign trig     = side ? sn : cs;
  assign trig_abs = trig[CW-1] ? (CW'(0) - trig) : trig;
  assign labs     = lin[31] ? (32'd0 - lin) : lin;
  assign pneg     = lin[31] ^ trig[CW-1];
  assign qq       = acc[98:58];
  assign pbase    = side ? pos_y : pos_x;
  assign psum     = $signed({{9{pbase[31]}}, pbase}) + $signed(pneg ? (41'd0 - qq) : qq);

  always_comb begin
    if (psum > 41'sd2147483647) begin
      psat = 32'sh7FFF_FFFF;
    end else if (psum < -41'sd2147483648) begin
      psat = 32'sh8000_0000;
    end else begin
      psat = psum[31:0];
    end
  end

  always_comb begin
    mac_ctl = '{en: 1'b0, clr: 1'b0, sh: SH_0};
    mac_a   = '0;
    mac_b   = '0;
    unique case (state)
      S_WM: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, sh: SH_0};
        mac_a   = dabs;
        mac_b   = mpt;
      end
      S_TM: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, sh: SH_0};
        mac_a   = diff_abs[31:0];
        mac_b   = {8'd0, itw};
      end
      S_AM: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, sh: SH_0};
        mac_a   = oabs;
        mac_b   = {16'd0, per};
      end
      S_K0: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, sh: SH_0};
        mac_a   = acc[31:0];
        mac_b   = YAW_K[31:0];
      end
      S_K1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, sh: SH_32};
        mac_a   = tmp[31:0];
        mac_b   = YAW_K[63:32];
      end
      S_K2: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, sh: SH_32};
        mac_a   = {2'b0, tmp[61:32]};
        mac_b   = YAW_K[31:0];
      end
      S_K3: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, sh: SH_64};
        mac_a   = {2'b0, tmp[61:32]};
        mac_b   = YAW_K[63:32];
      end
      S_PM0: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, sh: SH_0};
        mac_a   = labs;
        mac_b   = trig_abs[31:0];
      end
      S_PM1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, sh: SH_0};
        mac_a   = acc[31:0];
        mac_b   = {16'd0, per};
      end
      S_PM2: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, sh: SH_32};
        mac_a   = {2'b0, tmp[61:32]};
        mac_b   = {16'd0, per};
      end
      S_PD: begin
        mac_ctl = '{en: 1'b1, clr: 1'b1, sh: SH_0};
        mac_a   = acc[61:30];
        mac_b   = POS_RCP[31:0];
      end
      S_R1: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, sh: SH_32};
        mac_a   = tmp[31:0];
        mac_b   = POS_RCP[63:32];
      end
      S_R2: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, sh: SH_32};
        mac_a   = {2'b0, tmp[61:32]};
        mac_b   = POS_RCP[31:0];
      end
      S_R3: begin
        mac_ctl = '{en: 1'b1, clr: 1'b0, sh: SH_64};
        mac_a   = {2'b0, tmp[61:32]};
        mac_b   = POS_RCP[63:32];
      end
      default: begin
      end
    endcase
  end

  assign div_start    = (state == S_WD);
  assign div_divisor  = per;
  assign div_dividend = (m_ext << 10) - (m_ext << 4) - (m_ext << 3);

  dwo_mac u_mac (
    .clk (clk),
    .ctl (mac_ctl),
    .a   (mac_a),
    .b   (mac_b),
    .acc (acc)
  );

  dwo_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_q)
  );

  dwo_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_YW),
    .angle   (mid),
    .busy    (cor_busy),
    .cos_out (cor_cos),
    .sin_out (cor_sin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_l <= 1'b0;
      inv_r <= 1'b0;
      mpt   <= '0;
      itw   <= '0;
      nom_p <= 16'd10;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_INV_L: inv_l <= cfg_data[0];
        REG_INV_R: inv_r <= cfg_data[0];
        REG_MPT:   mpt   <= cfg_data;
        REG_ITW:   itw   <= cfg_data[23:0];
        REG_NOM:   nom_p <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      side      <= 1'b0;
      out_valid <= 1'b0;
      prev_l    <= '0;
      prev_r    <= '0;
      pos_x     <= '0;
      pos_y     <= '0;
      yaw       <= '0;
    end else begin
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_l  <= inv_l ? (32'd0 - left_count) : left_count;
            cur_r  <= inv_r ? (32'd0 - right_count) : right_count;
            per    <= per_in;
            imu_ok <= imu_valid;
            gyro   <= imu_yaw_rate;
            side   <= 1'b0;
            state  <= S_WM;
          end
        end
        S_WM: state <= S_WD;
        S_WD: state <= S_WW;
        S_WW: begin
          if (!div_busy) begin
            if (!side) begin
              ls    <= wsp;
              side  <= 1'b1;
              state <= S_WM;
            end else begin
              rs    <= wsp;
              state <= S_TM;
            end
          end
        end
        S_TM: state <= S_TN;
        S_TN: begin
          turn  <= turn_c;
          lin   <= sum_adj[32:1];
          omega <= omega_c;
          state <= S_AM;
        end
        S_AM: state <= S_K0;
        S_K0: begin
          tmp   <= acc[61:0];
          state <= S_K1;
        end
        S_K1: state <= S_K2;
        S_K2: state <= S_K3;
        S_K3: state <= S_YW;
        S_YW: begin
          dmag  <= dm;
          state <= S_CW;
        end
        S_CW: begin
          if (!cor_busy) begin
            cs    <= cor_cos;
            sn    <= cor_sin;
            side  <= 1'b0;
            state <= S_PM0;
          end
        end
        S_PM0: state <= S_PM1;
        S_PM1: begin
          tmp   <= acc[61:0];
          state <= S_PM2;
        end
        S_PM2: state <= S_PD;
        S_PD: begin
          tmp   <= {14'd0, acc[77:30]};
          state <= S_R1;
        end
        S_R1: state <= S_R2;
        S_R2: state <= S_R3;
        S_R3: state <= S_PW;
        S_PW: begin
          if (!side) begin
            new_x <= psat;
            side  <= 1'b1;
            state <= S_PM0;
          end else begin
            new_y <= psat;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            left_speed      <= ls;
            right_speed     <= rs;
            linear_speed    <= lin;
            wheel_turn_rate <= turn;
            pose_x          <= new_x;
            pose_y          <= new_y;
            heading         <= yaw + dmag;
            prev_l          <= cur_l;
            prev_r          <= cur_r;
            pos_x           <= new_x;
            pos_y           <= new_y;
            yaw             <= yaw + dmag;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a tick is in flight");

  a_result_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("result raised outside the output step");

  a_div_free_at_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_WD) |-> !div_busy)
    else $error("divider restarted while busy");

endmodule
`default_nettype wire

// ----- verif/diff_drive_wheel_odometry_test.sv -----
`timescale 1ns / 1ps
module diff_drive_wheel_odometry_test;
  import dwo_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam logic [2:0] CFG_UNUSED = 3'd7;
  localparam logic [31:0] ATAN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  typedef struct packed {
    logic [31:0] ls;
    logic [31:0] rs;
    logic [31:0] lin;
    logic [31:0] turn;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] hd;
  } odo_result_t;

  class pose_predictor;
    logic        inv_l, inv_r;
    logic [31:0] mpt;
    logic [23:0] itw;
    logic [15:0] nom;
    logic [31:0] prev_l, prev_r, yaw;
    longint      px, py;
    odo_result_t pending[$];
    int          errors;

    function new();
      inv_l = 0; inv_r = 0; mpt = 0; itw = 0; nom = 16'd10;
      prev_l = 0; prev_r = 0; yaw = 0; px = 0; py = 0; errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_INV_L: inv_l = d[0];
        REG_INV_R: inv_r = d[0];
        REG_MPT:   mpt = d;
        REG_ITW:   itw = d[23:0];
        REG_NOM:   nom = d[15:0];
        default: ;
      endcase
    endfunction

    function longint sat(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint speed(logic [31:0] delta, int unsigned per);
      logic        neg;
      logic [31:0] dm;
      logic [95:0] q;
      neg = delta[31];
      dm = neg ? -delta : delta;
      q = (96'(dm) * 96'(mpt) * 96'd1000) / (96'(per) << 16);
      if (neg) return (q > 96'h80000000) ? -64'sd2147483648 : -longint'(q[63:0]);
      return (q > 96'h7FFFFFFF) ? 64'sd2147483647 : longint'(q[63:0]);
    endfunction

    function void rotate(logic [31:0] ang, output longint c, output longint s);
      logic   flip;
      longint x, y, z, dx, dy;
      logic [31:0] t;
      t = ang + 32'h40000000;
      flip = t[31];
      if (flip) ang = ang + 32'h80000000;
      x = longint'(CORDIC_GAIN);
      y = 0;
      z = longint'($signed(ang));
      for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
        dx = x >>> i;
        dy = y >>> i;
        if (z >= 0) begin
          x = x - dy; y = y + dx; z = z - longint'(ATAN[i]);
        end else begin
          x = x + dy; y = y - dx; z = z + longint'(ATAN[i]);
        end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
    endfunction

    function longint travel(longint v, longint t, int unsigned per);
      logic         neg;
      logic [63:0]  vm, tm;
      logic [127:0] q;
      neg = (v < 0) != (t < 0);
      vm = (v < 0) ? -v : v;
      tm = (t < 0) ? -t : t;
      q = (128'(vm) * 128'(tm) * 128'(per)) / (128'd1000 << 30);
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function void note_tick(logic [31:0] lc, logic [31:0] rc, logic [15:0] p,
                            logic iv, logic signed [23:0] g);
      int unsigned  per;
      longint       ls, rs, lin, turn, omega, a, c, s;
      logic [63:0]  am;
      logic [127:0] prod;
      logic [31:0]  dm, hm;
      odo_result_t  r;
      per = (p == 0) ? nom : p;
      if (per == 0) per = 1;
      if (inv_l) lc = -lc;
      if (inv_r) rc = -rc;
      ls = speed(lc - prev_l, per);
      rs = speed(rc - prev_r, per);
      prev_l = lc;
      prev_r = rc;
      lin = (ls + rs) / 2;
      turn = sat(((rs - ls) * longint'(itw)) / 65536);
      omega = iv ? longint'(g) : turn;
      a = omega * longint'(per);
      am = (a < 0) ? -a : a;
      prod = 128'(am) * 128'(YAW_K);
      dm = prod[79:48];
      hm = prod[80:49];
      if (a < 0) begin
        dm = -dm; hm = -hm;
      end
      rotate(yaw + hm, c, s);
      px = sat(px + travel(lin, c, per));
      py = sat(py + travel(lin, s, per));
      yaw = yaw + dm;
      r.ls = ls[31:0]; r.rs = rs[31:0]; r.lin = lin[31:0]; r.turn = turn[31:0];
      r.px = px[31:0]; r.py = py[31:0]; r.hd = yaw;
      pending.push_back(r);
    endfunction

    function void check_result(odo_result_t got);
      odo_result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch exp ls %h rs %h lin %h turn %h x %h y %h hd %h",
                   exp_r.ls, exp_r.rs, exp_r.lin, exp_r.turn, exp_r.px, exp_r.py, exp_r.hd);
          $display("         got ls %h rs %h lin %h turn %h x %h y %h hd %h",
                   got.ls, got.rs, got.lin, got.turn, got.px, got.py, got.hd);
        end
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic signed [31:0] left_count, right_count;
  logic [15:0] period_ms;
  logic imu_valid;
  logic signed [23:0] imu_yaw_rate;
  logic out_valid, out_ready;
  logic signed [31:0] left_speed, right_speed, linear_speed, wheel_turn_rate;
  logic signed [31:0] pose_x, pose_y;
  logic [31:0] heading;

  pose_predictor odo;
  logic        calm;
  int          ready_hold;
  int          idle_cycles;
  logic [31:0] raw_l, raw_r;

  diff_drive_wheel_odometry u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .left_count(left_count), .right_count(right_count), .period_ms(period_ms),
    .imu_valid(imu_valid), .imu_yaw_rate(imu_yaw_rate),
    .out_valid(out_valid), .out_ready(out_ready),
    .left_speed(left_speed), .right_speed(right_speed), .linear_speed(linear_speed),
    .wheel_turn_rate(wheel_turn_rate), .pose_x(pose_x), .pose_y(pose_y), .heading(heading)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 30);
    return $urandom_range(100, 400);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_hold <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_valid && out_ready)
        odo.check_result({left_speed, right_speed, linear_speed, wheel_turn_rate,
                          pose_x, pose_y, heading});
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
      if (ready_hold > 0) begin
        ready_hold <= ready_hold - 1;
      end else begin
        out_ready <= calm || ($urandom_range(0, 3) != 0);
        ready_hold <= pick_gap();
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    odo.write_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_tick(logic [31:0] lc, logic [31:0] rc, logic [15:0] p,
                           logic iv, logic [23:0] g);
    int gap;
    in_valid <= 1'b1;
    left_count <= lc;
    right_count <= rc;
    period_ms <= p;
    imu_valid <= iv;
    imu_yaw_rate <= g;
    do @(posedge clk); while (!in_ready);
    odo.note_tick(lc, rc, p, iv, g);
    raw_l = lc;
    raw_r = rc;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (odo.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [31:0] step_count(logic [31:0] base);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return base + 32'($signed($urandom_range(0, 2000)) - 1000);
    if (r < 80) return base + 32'($signed($urandom_range(0, 2097152)) - 1048576);
    if (r < 90) return base;
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'($urandom_range(1, 50));
    if (r < 75) return 16'd0;
    if (r < 80) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic random_ticks(int n);
    logic [31:0] l, r;
    for (int i = 0; i < n; i++) begin
      l = step_count(raw_l);
      r = ($urandom_range(0, 3) == 0) ? step_count(raw_r) : step_count(l);
      send_tick(l, r, pick_period(), 1'($urandom_range(0, 1)), 24'($urandom));
    end
  endtask

  task automatic load_regs(logic il, logic ir, logic [31:0] m, logic [23:0] w, logic [15:0] n);
    write_reg(REG_INV_L, {31'd0, il});
    write_reg(REG_INV_R, {31'd0, ir});
    write_reg(REG_MPT, m);
    write_reg(REG_ITW, {8'd0, w});
    write_reg(REG_NOM, {16'd0, n});
  endtask

  initial begin
    odo = new();
    rst = 1'b1;
    calm = 1'b0;
    raw_l = 0;
    raw_r = 0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; left_count = '0; right_count = '0;
    period_ms = '0; imu_valid = 1'b0; imu_yaw_rate = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    random_ticks(60);
    drain();

    load_regs(1'b0, 1'b1, 32'hFFFFFFFF, 24'hFFFFFF, 16'd0);
    write_reg(CFG_UNUSED, 32'hFFFFFFFF);
    send_tick(32'h00000000, 32'h00000000, 16'd0, 1'b0, 24'h000000);
    send_tick(32'h7FFFFFFF, 32'h80000000, 16'd1, 1'b0, 24'h000000);
    send_tick(32'h80000000, 32'h7FFFFFFF, 16'hFFFF, 1'b0, 24'h000000);
    send_tick(32'hFFFFFFFF, 32'h00000001, 16'd0, 1'b1, 24'h7FFFFF);
    send_tick(32'h00000001, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 24'h800000);
    send_tick(32'h00000001, 32'hFFFFFFFF, 16'hFFFF, 1'b1, 24'h800000);
    send_tick(32'h00001000, 32'hFFFFF000, 16'd10, 1'b1, 24'h7FFFFF);
    send_tick(32'h00001000, 32'hFFFFF000, 16'd10, 1'b1, 24'hFFFFFF);
    send_tick(32'h40000000, 32'hC0000000, 16'd5, 1'b0, 24'h123456);
    send_tick(32'h00000000, 32'h00000000, 16'd0, 1'b1, 24'h000001);
    send_tick(32'h00000100, 32'h00000100, 16'd3, 1'b0, 24'h000000);
    send_tick(32'h00000300, 32'h00000100, 16'd3, 1'b0, 24'h000000);
    drain();

    load_regs(1'b1, 1'b0, 32'h00100000, 24'h028000, 16'd10);
    random_ticks(420);
    drain();

    load_regs(1'b1, 1'b1, 32'h00000001, 24'h000000, 16'hFFFF);
    send_tick(32'h80000000, 32'h80000000, 16'd0, 1'b0, 24'h000000);
    send_tick(32'h7FFFFFFF, 32'h00000000, 16'd0, 1'b1, 24'h7FFFFF);
    random_ticks(300);
    drain();

    calm = 1'b1;
    load_regs(1'b0, 1'b1, 32'h0A000000, 24'h010000, 16'd1);
    random_ticks(400);
    drain();
    calm = 1'b0;

    load_regs(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom,
              24'($urandom), 16'd20);
    random_ticks(350);
    drain();

    load_regs(1'b0, 1'b0, 32'h7FFFFFFF, 24'h7FFFFF, 16'd7);
    random_ticks(350);
    drain();

    if (odo.errors == 0 && odo.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/dwo_pkg.sv
sv/dwo_mac.sv
sv/dwo_div.sv
sv/dwo_cordic.sv
sv/diff_drive_wheel_odometry.sv
verif/diff_drive_wheel_odometry_test.sv
